// ===== rtl/swd_host_transaction_engine_macros.svh =====
// Assertion macros shared by the SWD host checker.
`ifndef SWD_HOST_TRANSACTION_ENGINE_MACROS_SVH
`define SWD_HOST_TRANSACTION_ENGINE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SWD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SWD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/swd_pkg.sv =====
// Types and constants of the SWD host transaction engine.
package swd_pkg;
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_ACCESS  = 2'd1;
   localparam logic [1:0] CMD_CONNECT = 2'd2;
   localparam logic [0:0] CSR_RETRY_LIMIT = 1'b0;
   localparam logic [0:0] CSR_IDLE_CYCLES = 1'b1;
   localparam logic [15:0] RETRY_LIMIT_RESET = 16'd1000;
   localparam logic [7:0]  IDLE_CYCLES_RESET = 8'd8;
   localparam logic [15:0] SWITCH_WORD  = 16'hE79E;
   localparam logic [7:0]  CONNECT_REQ  = 8'hA5;
   localparam logic [7:0]  REQ_FIXED    = 8'h81;
   localparam logic [2:0]  ACK_OK       = 3'd1;
   localparam logic [2:0]  ACK_WAIT     = 3'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic        ap_not_dp;
      logic        read_not_write;
      logic [1:0]  reg_addr;
      logic [31:0] write_data;
      logic        swdio_in;
   } req_type;

   typedef struct packed {
      logic        swdio_out;
      logic        swdio_drive;
      logic        clock_pulse;
      logic        busy_res;
      logic        done_res;
      logic [2:0]  ack_bits;
      logic        parity_error;
      logic [31:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic [0:0]  index;
      logic [31:0] data;
   } csr_type;

   typedef enum logic [9:0] {
      PH_IDLE    = 10'b0000000001,
      PH_RST1    = 10'b0000000010,
      PH_SWITCH  = 10'b0000000100,
      PH_RST2    = 10'b0000001000,
      PH_ZEROS   = 10'b0000010000,
      PH_REQ     = 10'b0000100000,
      PH_ACK     = 10'b0001000000,
      PH_RDATA   = 10'b0010000000,
      PH_WDATA   = 10'b0100000000,
      PH_IDLEOUT = 10'b1000000000
   } phase_type;
endpackage

// ===== rtl/swd_if.sv =====
// Valid/ready channel interfaces for transactions and register writes.
interface swd_req_if import swd_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface swd_rsp_if import swd_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface swd_csr_if import swd_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/swd_queue.sv =====
// Two-entry queue that decouples the front end from the bit engine.
module swd_queue import swd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output req_type out_data
);
   req_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule

// ===== rtl/swd_engine.sv =====
// Bit engine: runs at most one SWCLK period per transaction and registers the result.
module swd_engine import swd_pkg::*; #(
   parameter int unsigned RESET_ONES = 50
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  csr_type csr_data
);
   phase_type   phase_ff, phase_in;
   logic [7:0]  bit_count_ff, bit_count_in;
   logic [31:0] shift_word_ff, shift_word_in;
   logic [7:0]  request_byte_ff, request_byte_in;
   logic        parity_ff, parity_in;
   logic [15:0] retries_ff, retries_in;
   logic        line_in_ff, line_in_in;
   logic [2:0]  ack_ff, ack_in;
   logic        connect_ff, connect_in;
   logic [15:0] retry_limit_ff;
   logic [7:0]  idle_cycles_ff;
   logic        out_valid_ff;
   rsp_type     out_data_ff, rsp;
   logic        fire;

   assign in_ready  = !out_valid_ff || out_ready;
   assign fire      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign csr_ready = 1'b1;

   // Next-state logic for one tick.
   always_comb begin
      logic [7:0]  cnt_next;
      logic        b;
      logic        par;
      logic        v;
      logic [2:0]  ack_new;
      logic [15:0] ret_dec;
      phase_in        = phase_ff;
      bit_count_in    = bit_count_ff;
      shift_word_in   = shift_word_ff;
      request_byte_in = request_byte_ff;
      parity_in       = parity_ff;
      retries_in      = retries_ff;
      line_in_in      = line_in_ff;
      ack_in          = ack_ff;
      connect_in      = connect_ff;
      cnt_next        = bit_count_ff + 8'd1;
      b               = in_data.swdio_in;
      v               = 1'b0;
      ack_new         = 3'd0;
      ret_dec         = retries_ff - 16'd1;
      par = in_data.ap_not_dp ^ in_data.read_not_write ^ in_data.reg_addr[0]
            ^ in_data.reg_addr[1];
      rsp = '0;
      rsp.swdio_drive = !line_in_ff;
      if (phase_ff == PH_IDLE) begin
         if (in_data.command == CMD_ACCESS) begin
            request_byte_in = REQ_FIXED | {2'b0, par, in_data.reg_addr,
                              in_data.read_not_write, in_data.ap_not_dp, 1'b0};
            shift_word_in = in_data.read_not_write ? 32'd0 : in_data.write_data;
            connect_in = 1'b0;
            retries_in = (retry_limit_ff != 16'd0) ? retry_limit_ff : 16'd1;
            parity_in = 1'b0;
            ack_in = 3'd0;
            bit_count_in = 8'd0;
            phase_in = PH_REQ;
         end else if (in_data.command == CMD_CONNECT) begin
            request_byte_in = CONNECT_REQ;
            shift_word_in = 32'd0;
            connect_in = 1'b1;
            retries_in = 16'd0;
            parity_in = 1'b0;
            ack_in = 3'd0;
            bit_count_in = 8'd0;
            phase_in = PH_RST1;
         end
      end else begin
         rsp.clock_pulse = 1'b1;
         // Select the level of a driven bit.
         case (phase_ff)
            PH_SWITCH: v = SWITCH_WORD[bit_count_ff[3:0]];
            PH_REQ:    v = request_byte_ff[bit_count_ff[2:0]];
            PH_WDATA:  v = (bit_count_ff < 8'd32) ? shift_word_ff[bit_count_ff[4:0]]
                                                  : parity_ff;
            PH_RST1, PH_RST2: v = 1'b1;
            default:   v = 1'b0;
         endcase
         if (phase_ff inside {PH_ACK, PH_RDATA}) begin
            rsp.swdio_drive = 1'b0;
            if (!line_in_ff) begin
               line_in_in = 1'b1;
            end
         end else if (line_in_ff) begin
            rsp.swdio_drive = 1'b0;
            line_in_in = 1'b0;
         end else begin
            rsp.swdio_drive = 1'b1;
            rsp.swdio_out = v;
         end
         case (phase_ff)
            PH_RST1, PH_RST2: begin
               if (!line_in_ff) begin
                  bit_count_in = cnt_next;
                  if (cnt_next >= 8'(RESET_ONES)) begin
                     bit_count_in = 8'd0;
                     phase_in = (phase_ff == PH_RST1) ? PH_SWITCH : PH_ZEROS;
                  end
               end
            end
            PH_SWITCH, PH_ZEROS: begin
               if (!line_in_ff) begin
                  bit_count_in = cnt_next;
                  if (cnt_next >= 8'd16) begin
                     bit_count_in = 8'd0;
                     phase_in = (phase_ff == PH_SWITCH) ? PH_RST2 : PH_REQ;
                  end
               end
            end
            PH_REQ: begin
               if (!line_in_ff) begin
                  ack_in = 3'd0;
                  bit_count_in = cnt_next;
                  if (cnt_next >= 8'd8) begin
                     bit_count_in = 8'd0;
                     phase_in = PH_ACK;
                  end
               end
            end
            PH_ACK: begin
               if (line_in_ff) begin
                  ack_new = ack_ff | ({2'b0, b} << bit_count_ff[1:0]);
                  ack_in = ack_new;
                  bit_count_in = cnt_next;
                  if (cnt_next >= 8'd3) begin
                     bit_count_in = 8'd0;
                     if (connect_ff) begin
                        if (ack_new != ACK_OK) begin
                           phase_in = PH_IDLE;
                           rsp.done_res = 1'b1;
                           rsp.ack_bits = ack_new;
                           rsp.parity_error = 1'b1;
                        end else begin
                           phase_in = PH_RDATA;
                        end
                     end else begin
                        retries_in = ret_dec;
                        if (ack_new == ACK_WAIT && ret_dec != 16'd0) begin
                           phase_in = PH_REQ;
                        end else begin
                           phase_in = request_byte_ff[2] ? PH_RDATA : PH_WDATA;
                        end
                     end
                  end
               end
            end
            PH_RDATA: begin
               if (line_in_ff) begin
                  if (bit_count_ff < 8'd32) begin
                     shift_word_in[bit_count_ff[4:0]] = b;
                  end
                  parity_in = parity_ff ^ b;
                  bit_count_in = cnt_next;
                  if (cnt_next >= 8'd33) begin
                     bit_count_in = 8'd0;
                     if (connect_ff) begin
                        phase_in = PH_IDLE;
                        rsp.done_res = 1'b1;
                        rsp.ack_bits = ack_ff;
                        rsp.parity_error = (ack_ff != ACK_OK) || parity_in;
                        rsp.read_data = rsp.parity_error ? 32'd0 : shift_word_in;
                     end else begin
                        phase_in = PH_IDLEOUT;
                     end
                  end
               end
            end
            PH_WDATA: begin
               if (!line_in_ff) begin
                  if (bit_count_ff < 8'd32) begin
                     parity_in = parity_ff ^ v;
                  end
                  bit_count_in = cnt_next;
                  if (cnt_next >= 8'd33) begin
                     bit_count_in = 8'd0;
                     if (idle_cycles_ff == 8'd0) begin
                        phase_in = PH_IDLE;
                        rsp.done_res = 1'b1;
                        rsp.ack_bits = ack_ff;
                     end else begin
                        phase_in = PH_IDLEOUT;
                     end
                  end
               end
            end
            PH_IDLEOUT: begin
               if (!line_in_ff) begin
                  bit_count_in = cnt_next;
               end
               if ((line_in_ff && idle_cycles_ff == 8'd0) ||
                   (!line_in_ff && cnt_next >= idle_cycles_ff)) begin
                  phase_in = PH_IDLE;
                  rsp.done_res = 1'b1;
                  rsp.ack_bits = ack_ff;
                  if (request_byte_ff[2]) begin
                     rsp.parity_error = parity_ff;
                     rsp.read_data = shift_word_ff;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
      rsp.busy_res = (phase_in != PH_IDLE);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         bit_count_ff    <= 8'd0;
         shift_word_ff   <= 32'd0;
         request_byte_ff <= 8'd0;
         parity_ff       <= 1'b0;
         retries_ff      <= 16'd0;
         line_in_ff      <= 1'b0;
         ack_ff          <= 3'd0;
         connect_ff      <= 1'b0;
         out_valid_ff    <= 1'b0;
         retry_limit_ff  <= RETRY_LIMIT_RESET;
         idle_cycles_ff  <= IDLE_CYCLES_RESET;
      end else begin
         if (fire) begin
            phase_ff        <= phase_in;
            bit_count_ff    <= bit_count_in;
            shift_word_ff   <= shift_word_in;
            request_byte_ff <= request_byte_in;
            parity_ff       <= parity_in;
            retries_ff      <= retries_in;
            line_in_ff      <= line_in_in;
            ack_ff          <= ack_in;
            connect_ff      <= connect_in;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            if (csr_data.index == CSR_RETRY_LIMIT) begin
               retry_limit_ff <= csr_data.data[15:0];
            end else begin
               idle_cycles_ff <= csr_data.data[7:0];
            end
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= rsp;
      end
   end
endmodule

// ===== rtl/swd_host_transaction_engine.sv =====
// Top level of the SWD host transaction engine.
// Each accepted transaction passes the queue storage and then the engine's result register.
// Throughput: one transaction per cycle while results are taken, at most one SWCLK period per transaction.
// The rate is set by the single-cycle bit engine behind a two-entry queue.
// Synchronous reset idles the engine and loads retry_limit 1000, idle_cycles 8.
module swd_host_transaction_engine import swd_pkg::*; #(
   parameter int unsigned RESET_ONES = 50
) (
   input logic     clock,
   input logic     reset,
   swd_req_if.sink   req,
   swd_rsp_if.source rsp,
   swd_csr_if.sink   csr
);
   logic    q_valid, q_ready;
   req_type q_data;

   swd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_data   (req.data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   swd_engine #(.RESET_ONES(RESET_ONES)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp.data),
      .csr_valid (csr.valid),
      .csr_ready (csr.ready),
      .csr_data  (csr.data)
   );
endmodule

// ===== rtl/swd_checker.sv =====
// Port-level checker for the SWD host engine, bound to the top level.
`include "swd_host_transaction_engine_macros.svh"
module swd_checker import swd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   `SWD_ASSERT_IMPL(a_done_not_busy, clock, reset, rsp_valid && rsp_data.done_res, !rsp_data.busy_res, "done while busy")
   `SWD_ASSERT_IMPL(a_done_clocked, clock, reset, rsp_valid && rsp_data.done_res, rsp_data.clock_pulse, "done without clock")
   `SWD_ASSERT_IMPL(a_released_low, clock, reset, rsp_valid && !rsp_data.swdio_drive, !rsp_data.swdio_out, "released line high")
   `SWD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped")
endmodule

bind swd_host_transaction_engine swd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);

// ===== verif/swd_host_transaction_engine_checker.sv =====
// Checker for the SWD host engine: predicts each result and compares it with the block's output.
module swd_host_transaction_engine_checker import swd_pkg::*; #(
   parameter int unsigned RESET_ONES = 50
) (
   input  logic  clock,
   input  logic  reset,
   swd_req_if    req,
   swd_rsp_if    rsp,
   swd_csr_if    csr,
   output int    error_count,
   output int    pending_count,
   output int    checked_count,
   output int    finished_count,
   output logic  engine_busy
);

   // Configuration copy and engine state.
   logic [15:0] retry_lim;
   logic [7:0]  idle_len;
   phase_type   ph;
   logic [7:0]  bcnt;
   logic [31:0] sword;
   logic [7:0]  reqb;
   logic        rpar;
   logic [15:0] retries;
   logic        line_in;
   logic [2:0]  ackr;
   logic        conn;
   rsp_type     o;

   rsp_type wire_results[$];

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %0t: %s got %0h, expected %0h", $time, field, got, want);
      error_count++;
   endtask

   task automatic drive_bit(input logic b, output logic ok);
      if (line_in) begin
         line_in = 1'b0;
         o.swdio_out = 1'b0;
         o.swdio_drive = 1'b0;
         ok = 1'b0;
      end else begin
         o.swdio_out = b;
         o.swdio_drive = 1'b1;
         ok = 1'b1;
      end
   endtask

   task automatic sample_bit(output logic ok);
      o.swdio_out = 1'b0;
      o.swdio_drive = 1'b0;
      ok = line_in;
      line_in = 1'b1;
   endtask

   task automatic finish_seq();
      logic fail;
      ph = PH_IDLE;
      o.done_res = 1'b1;
      o.ack_bits = ackr;
      if (conn) begin
         fail = (ackr != ACK_OK) || rpar;
         o.parity_error = fail;
         o.read_data = fail ? 32'd0 : sword;
      end else if (reqb[2]) begin
         o.parity_error = rpar;
         o.read_data = sword;
      end
   endtask

   task automatic step_count(input phase_type nxt, input int unsigned len);
      bcnt++;
      if (bcnt >= len) begin
         bcnt = 8'd0;
         ph = nxt;
      end
   endtask

   // One SWCLK period of the running sequence.
   task automatic run_period(input logic din);
      logic ok;
      logic v;
      case (ph)
         PH_RST1, PH_RST2: begin
            drive_bit(1'b1, ok);
            if (ok) step_count(ph == PH_RST1 ? PH_SWITCH : PH_ZEROS, RESET_ONES);
         end
         PH_SWITCH: begin
            drive_bit(SWITCH_WORD[bcnt[3:0]], ok);
            if (ok) step_count(PH_RST2, 16);
         end
         PH_ZEROS: begin
            drive_bit(1'b0, ok);
            if (ok) step_count(PH_REQ, 16);
         end
         PH_REQ: begin
            drive_bit(reqb[bcnt[2:0]], ok);
            if (ok) begin
               ackr = 3'd0;
               step_count(PH_ACK, 8);
            end
         end
         PH_ACK: begin
            sample_bit(ok);
            if (ok) begin
               ackr = ackr | (3'(din) << bcnt[1:0]);
               bcnt++;
               if (bcnt >= 3) begin
                  bcnt = 8'd0;
                  if (conn) begin
                     if (ackr != ACK_OK) finish_seq();
                     else ph = PH_RDATA;
                  end else begin
                     retries--;
                     if (ackr == ACK_WAIT && retries != 16'd0) ph = PH_REQ;
                     else ph = reqb[2] ? PH_RDATA : PH_WDATA;
                  end
               end
            end
         end
         PH_RDATA: begin
            sample_bit(ok);
            if (ok) begin
               if (bcnt < 32) sword[bcnt[4:0]] = sword[bcnt[4:0]] | din;
               rpar ^= din;
               bcnt++;
               if (bcnt >= 33) begin
                  bcnt = 8'd0;
                  if (conn) finish_seq();
                  else ph = PH_IDLEOUT;
               end
            end
         end
         PH_WDATA: begin
            v = (bcnt < 32) ? sword[bcnt[4:0]] : rpar;
            drive_bit(v, ok);
            if (ok) begin
               if (bcnt < 32) rpar ^= v;
               bcnt++;
               if (bcnt >= 33) begin
                  bcnt = 8'd0;
                  if (idle_len == 8'd0) finish_seq();
                  else ph = PH_IDLEOUT;
               end
            end
         end
         PH_IDLEOUT: begin
            drive_bit(1'b0, ok);
            if (!ok) begin
               if (idle_len == 8'd0) finish_seq();
            end else begin
               bcnt++;
               if (bcnt >= idle_len) finish_seq();
            end
         end
         default: ph = PH_IDLE;
      endcase
   endtask

   // Expected result of one accepted transaction.
   task automatic predict(input req_type r);
      logic par;
      logic pulse;
      o = '0;
      o.swdio_drive = !line_in;
      pulse = 1'b0;
      if (ph == PH_IDLE) begin
         if (r.command == CMD_ACCESS) begin
            par = r.ap_not_dp ^ r.read_not_write ^ r.reg_addr[0] ^ r.reg_addr[1];
            reqb = REQ_FIXED | {2'b00, par, r.reg_addr, r.read_not_write, r.ap_not_dp, 1'b0};
            sword = r.read_not_write ? 32'd0 : r.write_data;
            conn = 1'b0;
            retries = (retry_lim != 16'd0) ? retry_lim : 16'd1;
            rpar = 1'b0;
            ackr = 3'd0;
            bcnt = 8'd0;
            ph = PH_REQ;
         end else if (r.command == CMD_CONNECT) begin
            reqb = CONNECT_REQ;
            sword = 32'd0;
            conn = 1'b1;
            retries = 16'd0;
            rpar = 1'b0;
            ackr = 3'd0;
            bcnt = 8'd0;
            ph = PH_RST1;
         end
      end else begin
         pulse = 1'b1;
         run_period(r.swdio_in);
      end
      o.clock_pulse = pulse;
      o.busy_res = (ph != PH_IDLE);
      wire_results.push_back(o);
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report(field, got, want);
   endtask

   // Watch all three channels at every rising clock edge.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         retry_lim = RETRY_LIMIT_RESET;
         idle_len = IDLE_CYCLES_RESET;
         ph = PH_IDLE;
         bcnt = 8'd0;
         sword = 32'd0;
         reqb = 8'd0;
         rpar = 1'b0;
         retries = 16'd0;
         line_in = 1'b0;
         ackr = 3'd0;
         conn = 1'b0;
         wire_results.delete();
         error_count = 0;
         checked_count = 0;
         finished_count = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.data.index == CSR_RETRY_LIMIT) retry_lim = csr.data.data[15:0];
            else idle_len = csr.data.data[7:0];
         end
         if (req.valid && req.ready) predict(req.data);
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            if (wire_results.size() == 0) begin
               report("unexpected transaction", 32'd0, 32'd0);
            end else begin
               want = wire_results.pop_front();
               check_field("swdio_out", got.swdio_out, want.swdio_out);
               check_field("swdio_drive", got.swdio_drive, want.swdio_drive);
               check_field("clock_pulse", got.clock_pulse, want.clock_pulse);
               check_field("busy_res", got.busy_res, want.busy_res);
               check_field("done_res", got.done_res, want.done_res);
               check_field("ack_bits", got.ack_bits, want.ack_bits);
               check_field("parity_error", got.parity_error, want.parity_error);
               check_field("read_data", got.read_data, want.read_data);
               checked_count++;
               if (want.done_res) finished_count++;
            end
         end
      end
      pending_count = wire_results.size();
      engine_busy = (ph != PH_IDLE);
   end

endmodule

// ===== verif/swd_host_transaction_engine_tb.sv =====
// Testbench top for the SWD host engine: clock, reset, stimulus and verdict.
module swd_host_transaction_engine_tb;
   import swd_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // Tick offsets of the first ack bit after a start, with the line driven at start.
   localparam int ACCESS_ACK_AT = 10;
   localparam int CONNECT_ACK_AT = 142;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   int   checked_count;
   int   finished_count;
   logic engine_busy;

   int   snd_pct;
   int   rcv_pct;
   int   idle_now;
   int   sent;
   int   hold_len;
   logic hold_trig;
   logic hold_seen = 1'b0;
   int   hold_cnt = 0;

   swd_req_if req ();
   swd_rsp_if rsp ();
   swd_csr_if csr ();

   swd_host_transaction_engine u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   swd_host_transaction_engine_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .rsp            (rsp),
      .csr            (csr),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .finished_count (finished_count),
      .engine_busy    (engine_busy)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Result side: random stalls plus a long hold-off on request.
   initial rsp.ready = 1'b0;
   always @(posedge clock) begin
      if (hold_trig != hold_seen) begin
         hold_seen <= hold_trig;
         hold_cnt <= hold_len;
         rsp.ready <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= rcv_pct);
      end
   end

   // Give up after a generous fixed time.
   initial begin
      #4000000;
      $display("swd_host_transaction_engine_tb: errors");
      $finish;
   end

   task automatic send_item(input req_type t);
      while ($urandom_range(99) < snd_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= t;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent++;
   endtask

   function automatic req_type tick_item(input logic din);
      req_type t;
      t.command = ($urandom_range(9) == 0) ? CMD_UNUSED : CMD_TICK;
      t.ap_not_dp = $urandom_range(1);
      t.read_not_write = $urandom_range(1);
      t.reg_addr = $urandom_range(3);
      t.write_data = $urandom;
      t.swdio_in = din;
      return t;
   endfunction

   function automatic logic [2:0] pick_ack();
      int r;
      r = $urandom_range(9);
      if (r < 6) return ACK_OK;
      if (r < 8) return ACK_WAIT;
      return $urandom_range(7);
   endfunction

   // A start, then enough ticks to run the sequence when it is not retried, with the ack shaped at its slot.
   task automatic run_sequence(input logic [1:0] cmd, input logic ap, input logic rnw,
                               input logic [1:0] addr, input logic [31:0] wd,
                               input logic [2:0] ack, input logic [1:0] busy_cmd);
      req_type t;
      int ack_at;
      int len;
      logic din;
      t.command = cmd;
      t.ap_not_dp = ap;
      t.read_not_write = rnw;
      t.reg_addr = addr;
      t.write_data = wd;
      t.swdio_in = $urandom_range(1);
      send_item(t);
      ack_at = (cmd == CMD_CONNECT) ? CONNECT_ACK_AT : ACCESS_ACK_AT;
      len = (cmd == CMD_CONNECT) ? 178 : 47 + idle_now;
      for (int off = 1; off <= len; off++) begin
         if (off >= ack_at && off < ack_at + 3) din = ack[off - ack_at];
         else din = $urandom_range(1);
         t = tick_item(din);
         if (off == 5 && busy_cmd != CMD_TICK) t.command = busy_cmd;
         send_item(t);
      end
   endtask

   // Finish any running sequence, drain results, then write one register.
   task automatic settle_and_write(input logic [0:0] idx, input logic [31:0] val);
      while (engine_busy) send_item(tick_item($urandom_range(1)));
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr.valid <= 1'b1;
      csr.data.index <= idx;
      csr.data.data <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      if (idx == CSR_IDLE_CYCLES) idle_now = val[7:0];
   endtask

   task automatic random_phase(input int count);
      int stop_at;
      int pick;
      stop_at = sent + count;
      while (sent < stop_at) begin
         pick = $urandom_range(9);
         if (pick < 7) begin
            run_sequence(CMD_ACCESS, $urandom_range(1), $urandom_range(1), $urandom_range(3),
                         $urandom, pick_ack(), CMD_TICK);
         end else if (pick == 7) begin
            run_sequence(CMD_CONNECT, 1'b0, 1'b0, 2'd0, $urandom, pick_ack(), CMD_TICK);
         end else begin
            repeat ($urandom_range(20, 1)) send_item(tick_item($urandom_range(1)));
         end
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      hold_trig = 1'b0;
      hold_len = 300;
      snd_pct = 0;
      rcv_pct = 0;
      idle_now = IDLE_CYCLES_RESET;
      sent = 0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle ticks, reads, writes, fault, start while busy, connects.
      send_item(tick_item(1'b1));
      begin
         req_type t;
         t = tick_item(1'b0);
         t.command = CMD_UNUSED;
         send_item(t);
      end
      run_sequence(CMD_ACCESS, 1'b0, 1'b1, 2'd0, 32'd0, ACK_OK, CMD_TICK);
      run_sequence(CMD_ACCESS, 1'b1, 1'b0, 2'd3, 32'hFFFF_FFFF, ACK_OK, CMD_CONNECT);
      run_sequence(CMD_ACCESS, 1'b0, 1'b0, 2'd1, 32'd0, 3'b100, CMD_ACCESS);
      run_sequence(CMD_ACCESS, 1'b1, 1'b1, 2'd2, 32'h1234_5678, ACK_WAIT, CMD_TICK);
      run_sequence(CMD_CONNECT, 1'b0, 1'b0, 2'd0, 32'd0, ACK_OK, CMD_TICK);
      run_sequence(CMD_CONNECT, 1'b0, 1'b0, 2'd0, 32'd0, 3'b111, CMD_TICK);
      run_sequence(CMD_ACCESS, 1'b0, 1'b1, 2'd1, 32'd0, ACK_OK, CMD_TICK);

      // Zero retry limit and zero idle cycles.
      settle_and_write(CSR_RETRY_LIMIT, 32'd0);
      settle_and_write(CSR_IDLE_CYCLES, 32'd0);
      run_sequence(CMD_ACCESS, 1'b1, 1'b1, 2'd3, 32'd0, ACK_WAIT, CMD_TICK);
      run_sequence(CMD_ACCESS, 1'b0, 1'b0, 2'd2, $urandom, ACK_OK, CMD_TICK);

      // Random, sender sparse stalls, receiver heavy stalls, widest settings.
      settle_and_write(CSR_RETRY_LIMIT, 32'd65535);
      settle_and_write(CSR_IDLE_CYCLES, 32'd255);
      snd_pct = 9;
      rcv_pct = 54;
      random_phase(1);

      // Roles swapped, narrowest settings.
      settle_and_write(CSR_RETRY_LIMIT, 32'd1);
      settle_and_write(CSR_IDLE_CYCLES, 32'd0);
      snd_pct = 54;
      rcv_pct = 9;
      random_phase(10);

      // No stalls, with one long hold-off on the result side.
      settle_and_write(CSR_RETRY_LIMIT, 32'd3);
      settle_and_write(CSR_IDLE_CYCLES, 32'd2);
      snd_pct = 0;
      rcv_pct = 0;
      hold_trig <= ~hold_trig;
      random_phase(10);

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("checked %0d result transactions from %0d sent, %0d sequences finished",
               checked_count, sent, finished_count);
      $display("covered accesses, connects, WAIT retries and retry/idle settings at both ends");
      if (error_count == 0) begin
         $display("swd_host_transaction_engine_tb: clean");
      end else begin
         $display("swd_host_transaction_engine_tb: errors");
      end
      $finish;
   end

endmodule
